>>> hw/rtl/tlbf_pkg.sv
// shared types, constants and helpers for the fifo/lru translation buffer
package tlbf_pkg;

	// default number of entries
	localparam int TLB_DEPTH_DEF = 16;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int PID_W    = 16;
	localparam int FRAME_W  = 20;
	localparam int OFS_W    = 16;
	localparam int PAGE_W   = 28;
	localparam int STAMP_W  = 32;
	localparam int FILL_W   = STAMP_W + FRAME_W;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int CFG_W    = 5;

	// offset width limits
	localparam logic [CFG_W-1:0] OFS_BITS_MIN = 5'd4;
	localparam logic [CFG_W-1:0] OFS_BITS_MAX = 5'd16;

	// register reset values
	localparam logic [CFG_W-1:0] OFS_BITS_RST = 5'd12;
	localparam logic [CFG_W-1:0] CAP_RST      = 5'd16;

	// register indexes
	typedef enum logic [1:0] {
		REG_PAGE_OFFSET = 2'd0,
		REG_CAPACITY    = 2'd1,
		REG_MODE        = 2'd2
	} reg_idx_t;

	// input action codes
	localparam logic ACT_TRANSLATE = 1'b0;

	// replacement mode codes
	localparam logic MODE_FIFO = 1'b0;

	// result status codes
	typedef enum logic [1:0] {
		ST_HIT        = 2'd0,
		ST_MISS       = 2'd1,
		ST_FILLED     = 2'd2,
		ST_FILL_ERROR = 2'd3
	} status_t;

	// classified command kinds
	typedef enum logic [1:0] {
		CMD_TRANSLATE,
		CMD_FILL,
		CMD_FILL_ERR
	} cmd_kind_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_READ,
		BK_SCAN,
		BK_REPL,
		BK_DONE
	} back_state_t;

	// command handed from front to back
	typedef struct packed {
		cmd_kind_t            kind;
		logic [PID_W-1:0]     pid;
		logic [PAGE_W-1:0]    page;
		logic [FRAME_W-1:0]   frame;
		logic [OFS_W-1:0]     offset;
		logic [ADDR_W-1:0]    phys;
	} cmd_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [CFG_W-1:0] ofs_bits;
		logic [CFG_W-1:0] capacity;
		logic             mode;
	} cfg_t;

	// one result item
	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  phys;
		logic [3:0]         idx;
	} res_t;

	// frame shifted up by the page size plus the offset, modulo 2^32
	function automatic logic [ADDR_W-1:0] make_phys(input logic [FRAME_W-1:0] frame,
		input logic [OFS_W-1:0] offset, input logic [CFG_W-1:0] bits);
		logic [ADDR_W-1:0] base;
		base = {12'b0, frame} << bits;
		return base + {16'b0, offset};
	endfunction

endpackage

>>> hw/rtl/tlbf_ram.sv
// generic single write port ram with registered read
module tlbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/tlbf_front.sv
// front end: unpacks input items and classifies them into commands
module tlbf_front import tlbf_pkg::*; (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [71:0]        s_tdata,   // logical_address, process_id, frame_number, frame_error
	input  logic [0:0]         s_tuser,   // action
	input  logic [CFG_W-1:0]   ofs_bits,
	output logic               push_valid,
	input  logic               push_ready,
	output cmd_t               push_cmd
);

	logic [ADDR_W-1:0]  laddr;
	logic [PID_W-1:0]   pid;
	logic [FRAME_W-1:0] frame;
	logic               ferr;
	logic [ADDR_W-1:0]  shifted;
	logic [OFS_W:0]     ofs_lim;
	logic [OFS_W:0]     ofs_mask;
	logic [OFS_W-1:0]   offset;

	// unpack the item
	assign laddr = s_tdata[31:0];
	assign pid   = s_tdata[47:32];
	assign frame = s_tdata[67:48];
	assign ferr  = s_tdata[68];

	// split address into page and offset
	assign shifted  = laddr >> ofs_bits;
	assign ofs_lim  = (OFS_W+1)'(1) << ofs_bits;
	assign ofs_mask = ofs_lim - (OFS_W+1)'(1);
	assign offset   = laddr[OFS_W-1:0] & ofs_mask[OFS_W-1:0];

	// classify and build the command
	always_comb begin
		push_cmd.pid    = pid;
		push_cmd.page   = shifted[PAGE_W-1:0];
		push_cmd.frame  = frame;
		push_cmd.offset = offset;
		push_cmd.phys   = make_phys(frame, offset, ofs_bits);
		if (s_tuser[0] == ACT_TRANSLATE) begin
			push_cmd.kind = CMD_TRANSLATE;
		end else if (ferr) begin
			push_cmd.kind = CMD_FILL_ERR;
		end else begin
			push_cmd.kind = CMD_FILL;
		end
	end

	// handshake
	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

endmodule

>>> hw/rtl/tlbf_queue.sv
// two-entry command queue between front and back
module tlbf_queue import tlbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop,
	output cmd_t pop_cmd
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/tlbf_back.sv
// back end: tag match, victim scan, entry update and result register
module tlbf_back import tlbf_pkg::*; #(
	parameter int TLB_DEPTH = TLB_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	input  cfg_t cfg,
	output logic m_valid,
	input  logic m_ready,
	output res_t m_res
);

	localparam int IDXW  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int CNTB  = $clog2(TLB_DEPTH + 1);
	localparam int CAPW  = (CNTB > CFG_W) ? CNTB : CFG_W;

	// widen an entry number to the 4-bit result field
	function automatic logic [3:0] idx4(input logic [IDXW-1:0] x);
		logic [IDXW+3:0] w;
		w = {4'b0000, x};
		return w[3:0];
	endfunction

	back_state_t        state_q, state_nx;
	cmd_t               cmd_q;
	logic [CAPW-1:0]    occ_q;
	logic [STAMP_W-1:0] counter_q;
	logic [PID_W-1:0]   proc_q [TLB_DEPTH];
	logic [PAGE_W-1:0]  page_q [TLB_DEPTH];
	logic [IDXW-1:0]    rd_idx_q;
	logic [IDXW-1:0]    vic_q;
	logic [STAMP_W-1:0] best_q;
	res_t               res_q;
	logic               out_valid_q;
	res_t               out_res_q;

	logic [CAPW-1:0]    cap;
	logic [CAPW-1:0]    live;
	logic [TLB_DEPTH-1:0] match;
	logic               hit_any;
	logic [IDXW-1:0]    hit_idx;
	logic [STAMP_W-1:0] counter_inc;
	logic [FILL_W-1:0]  fill_rdata;
	logic [STAMP_W-1:0] used_rdata;
	logic [STAMP_W-1:0] stamp_sel;
	logic               take;
	logic [CAPW-1:0]    rd_next;
	logic               scan_last;
	logic               has_room;
	logic               out_free;

	// control from the per-state block
	logic [IDXW-1:0]    ram_raddr;
	logic               wr_en;
	logic [IDXW-1:0]    wr_idx;
	logic               touch_en;
	logic               res_load;
	res_t               res_nx;
	logic               cnt_inc;
	logic               occ_inc;
	logic               scan_start;
	logic               scan_step;
	logic               out_load;

	logic               used_we;
	logic [IDXW-1:0]    used_waddr;
	logic [STAMP_W-1:0] used_wdata;

	// capacity clamp and live entries
	assign cap = (CAPW'(cfg.capacity) > CAPW'(TLB_DEPTH)) ? CAPW'(TLB_DEPTH)
		: CAPW'(cfg.capacity);
	assign live        = (occ_q < cap) ? occ_q : cap;
	assign has_room    = (occ_q < cap);
	assign counter_inc = counter_q + STAMP_W'(1);
	assign out_free    = !out_valid_q || m_ready;

	// parallel tag compare over live entries
	always_comb begin
		for (int i = 0; i < TLB_DEPTH; i++) begin
			match[i] = (CAPW'(i) < live) && (proc_q[i] == cmd_q.pid)
				&& (page_q[i] == cmd_q.page);
		end
	end

	// lowest matching entry
	always_comb begin
		hit_idx = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDXW'(i);
			end
		end
	end
	assign hit_any = |match;

	// victim scan compare on the entry read last cycle
	assign stamp_sel = (cfg.mode == MODE_FIFO) ? fill_rdata[FILL_W-1:FRAME_W] : used_rdata;
	assign take      = (rd_idx_q == '0) || (stamp_sel < best_q);
	assign rd_next   = CAPW'(rd_idx_q) + CAPW'(1);
	assign scan_last = (rd_next >= cap);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_nx = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_nx = BK_DONE;
				case (cmd_q.kind)
					CMD_TRANSLATE: begin
						if (live != '0 && hit_any) begin
							state_nx = BK_READ;
						end
					end
					CMD_FILL: begin
						if (!has_room && cap != '0) begin
							state_nx = BK_SCAN;
						end
					end
					default: state_nx = BK_DONE;
				endcase
			end
			BK_READ: state_nx = BK_DONE;
			BK_SCAN: begin
				if (scan_last) begin
					state_nx = BK_REPL;
				end
			end
			BK_REPL: state_nx = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// per-state controls
	always_comb begin
		q_pop       = 1'b0;
		ram_raddr   = '0;
		wr_en       = 1'b0;
		wr_idx      = '0;
		touch_en    = 1'b0;
		res_load    = 1'b0;
		res_nx      = res_q;
		cnt_inc     = 1'b0;
		occ_inc     = 1'b0;
		scan_start  = 1'b0;
		scan_step   = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
			end
			BK_EXEC: begin
				res_load = 1'b1;
				res_nx.phys = '0;
				res_nx.idx  = '0;
				case (cmd_q.kind)
					CMD_TRANSLATE: begin
						res_nx.status = ST_MISS;
						if (live != '0) begin
							cnt_inc = 1'b1;
							if (hit_any) begin
								touch_en      = 1'b1;
								ram_raddr     = hit_idx;
								res_nx.status = ST_HIT;
								res_nx.idx    = idx4(hit_idx);
							end
						end
					end
					CMD_FILL: begin
						res_nx.status = ST_FILLED;
						res_nx.phys   = cmd_q.phys;
						if (has_room) begin
							wr_en      = 1'b1;
							wr_idx     = occ_q[IDXW-1:0];
							occ_inc    = 1'b1;
							res_nx.idx = idx4(occ_q[IDXW-1:0]);
						end else if (cap != '0) begin
							scan_start = 1'b1;
							ram_raddr  = '0;
						end
					end
					default: begin
						res_nx.status = ST_FILL_ERROR;
					end
				endcase
			end
			BK_READ: begin
				res_load    = 1'b1;
				res_nx.phys = make_phys(fill_rdata[FRAME_W-1:0], cmd_q.offset, cfg.ofs_bits);
			end
			BK_SCAN: begin
				scan_step = 1'b1;
				ram_raddr = rd_next[IDXW-1:0];
			end
			BK_REPL: begin
				wr_en      = 1'b1;
				wr_idx     = vic_q;
				res_load   = 1'b1;
				res_nx.idx = idx4(vic_q);
			end
			BK_DONE: begin
				out_load = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// last-use ram port: fill stamps current count, hit stamps the bumped count
	assign used_we    = wr_en || touch_en;
	assign used_waddr = wr_en ? wr_idx : hit_idx;
	assign used_wdata = wr_en ? counter_q : counter_inc;

	// insertion stamp and frame per entry
	tlbf_ram #(
		.WIDTH(FILL_W),
		.DEPTH(TLB_DEPTH)
	) u_fill_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata ({counter_q, cmd_q.frame}),
		.raddr (ram_raddr),
		.rdata (fill_rdata)
	);

	// last-use stamp per entry
	tlbf_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(TLB_DEPTH)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (ram_raddr),
		.rdata (used_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			occ_q       <= '0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (occ_inc) begin
				occ_q <= occ_q + CAPW'(1);
			end
			if (cnt_inc) begin
				counter_q <= counter_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: command, tags, scan and results
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (wr_en) begin
			proc_q[wr_idx] <= cmd_q.pid;
			page_q[wr_idx] <= cmd_q.page;
		end
		if (scan_start) begin
			rd_idx_q <= '0;
		end else if (scan_step) begin
			rd_idx_q <= rd_next[IDXW-1:0];
			if (take) begin
				best_q <= stamp_sel;
				vic_q  <= rd_idx_q;
			end
		end
		if (res_load) begin
			res_q <= res_nx;
		end
		if (out_load) begin
			out_res_q <= res_q;
		end
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_res_q;

endmodule

>>> hw/rtl/tlb_fifo_lru_translation.sv
// top level: configuration registers, front end, command queue and back end
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser | translate or fill request item
//  m_axis   | m_tvalid m_tready m_tdata m_tuser | one result item per request
//  apb      | psel penable pwrite paddr pwdata  | page offset bits, capacity, mode
//
// the back-end sequencer handles one item at a time: a miss, fill error or fill
// into free space passes idle, exec and done; a hit adds a read state (registered
// read of the frame ram), and a fill that evicts adds a scan over the capacity (one
// entry scanned per cycle through the stamp rams) and a replace state. done waits for a free
// output register. a two-item queue lets the input keep accepting while the back end works
// and a result waits in the output register. reset clears occupancy, the access counter and all handshakes.
module tlb_fifo_lru_translation import tlbf_pkg::*; #(
	parameter int TLB_DEPTH = TLB_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [71:0]        s_tdata,   // logical_address, process_id, frame_number, frame_error
	input  logic [0:0]         s_tuser,   // action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,   // physical_address, entry_index
	output logic [1:0]         m_tuser,   // status
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CFG_W-1:0] ofs_bits_q;
	logic [CFG_W-1:0] capacity_q;
	logic             mode_q;
	logic [CFG_W-1:0] ofs_bits_c;
	logic             cfg_wr;
	reg_idx_t         reg_idx;
	cfg_t             cfg;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop;
	cmd_t pop_cmd;
	res_t res;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_bits_q <= OFS_BITS_RST;
			capacity_q <= CAP_RST;
			mode_q     <= MODE_FIFO;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PAGE_OFFSET: ofs_bits_q <= pwdata[CFG_W-1:0];
				REG_CAPACITY:    capacity_q <= pwdata[CFG_W-1:0];
				REG_MODE:        mode_q     <= pwdata[0];
				default:         mode_q     <= mode_q;
			endcase
		end
	end

	// register read
	always_comb begin
		case (reg_idx)
			REG_PAGE_OFFSET: prdata = {27'b0, ofs_bits_q};
			REG_CAPACITY:    prdata = {27'b0, capacity_q};
			REG_MODE:        prdata = {31'b0, mode_q};
			default:         prdata = '0;
		endcase
	end

	// offset width clamped to the supported range
	assign ofs_bits_c = (ofs_bits_q < OFS_BITS_MIN) ? OFS_BITS_MIN
		: (ofs_bits_q > OFS_BITS_MAX) ? OFS_BITS_MAX : ofs_bits_q;

	assign cfg.ofs_bits = ofs_bits_c;
	assign cfg.capacity = capacity_q;
	assign cfg.mode     = mode_q;

	tlbf_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.ofs_bits   (ofs_bits_c),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tlbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	tlbf_back #(
		.TLB_DEPTH(TLB_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_cmd   (pop_cmd),
		.q_pop   (pop),
		.cfg     (cfg),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (res)
	);

	// pack the result item
	assign m_tdata = {4'b0000, res.idx, res.phys};
	assign m_tuser = res.status;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the fifo/lru translation buffer: directed cases, then random traffic
`timescale 1ns / 100ps

module tb_top;
	import tlbf_pkg::*;

	localparam int   TLB_DEPTH  = 16;
	localparam int   CYCLE_CAP  = 400000;
	localparam int   DRAIN_WAIT = 24;
	localparam logic ACT_FILL   = 1'b1;
	localparam logic MODE_LRU   = 1'b1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [71:0]        s_tdata;   // logical_address, process_id, frame_number, frame_error
	logic [0:0]         s_tuser;   // action
	logic               m_tvalid;
	logic               m_tready;
	logic [39:0]        m_tdata;   // physical_address, entry_index
	logic [1:0]         m_tuser;   // status
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// shadow of the translation buffer
	logic [PID_W-1:0]   tag_pid   [TLB_DEPTH];
	logic [PAGE_W-1:0]  tag_page  [TLB_DEPTH];
	logic [FRAME_W-1:0] ent_frame [TLB_DEPTH];
	logic [STAMP_W-1:0] ins_stamp [TLB_DEPTH];
	logic [STAMP_W-1:0] use_stamp [TLB_DEPTH];
	int unsigned        occupancy;
	logic [STAMP_W-1:0] access_count;
	logic [CFG_W-1:0]   cfg_ofs_bits;
	logic [CFG_W-1:0]   cfg_capacity;
	logic               cfg_mode;

	res_t tlb_expect [$];

	int n_fails;
	int n_items;
	int n_settings;
	int n_hits;
	int n_misses;
	int n_evictions;
	int n_fill_errs;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold;
	int cycle_count;

	tlb_fifo_lru_translation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// page offset width after clamping
	function automatic int unsigned offset_width();
		if (cfg_ofs_bits < OFS_BITS_MIN) return OFS_BITS_MIN;
		if (cfg_ofs_bits > OFS_BITS_MAX) return OFS_BITS_MAX;
		return cfg_ofs_bits;
	endfunction

	// frame shifted by the page size plus offset, wrapped to 32 bits
	function automatic logic [ADDR_W-1:0] phys_of(input logic [FRAME_W-1:0] frame,
		input logic [ADDR_W-1:0] ofs, input int unsigned nbits);
		logic [ADDR_W-1:0] base;
		base = {12'b0, frame} << nbits;
		return base + ofs;
	endfunction

	// expected result of one item; updates the shadow buffer
	function automatic res_t predict_tlb(input logic act, input logic [ADDR_W-1:0] addr,
		input logic [PID_W-1:0] pid, input logic [FRAME_W-1:0] frame, input logic ferr);
		int unsigned       nbits;
		int unsigned       cap;
		int unsigned       live;
		int unsigned       slot;
		int unsigned       i;
		logic [ADDR_W-1:0] page;
		logic [ADDR_W-1:0] ofs;
		logic [STAMP_W-1:0] a;
		logic [STAMP_W-1:0] b;
		bit                found;
		bit                do_store;
		res_t              r;
		nbits    = offset_width();
		page     = addr >> nbits;
		ofs      = addr & ((32'd1 << nbits) - 32'd1);
		cap      = (cfg_capacity > TLB_DEPTH) ? TLB_DEPTH : cfg_capacity;
		live     = (occupancy < cap) ? occupancy : cap;
		r.status = ST_MISS;
		r.phys   = '0;
		r.idx    = '0;
		found    = 1'b0;
		do_store = 1'b0;
		slot     = 0;
		if (act == ACT_TRANSLATE) begin
			// search live entries, lowest index wins
			if (live > 0) begin
				access_count = access_count + 32'd1;
				for (i = 0; i < live; i++) begin
					if (!found && tag_pid[i] == pid && tag_page[i] == page[PAGE_W-1:0]) begin
						found        = 1'b1;
						use_stamp[i] = access_count;
						r.status     = ST_HIT;
						r.phys       = phys_of(ent_frame[i], ofs, nbits);
						r.idx        = 4'(i);
					end
				end
			end
			if (found) n_hits++;
			else n_misses++;
		end else if (ferr) begin
			r.status = ST_FILL_ERROR;
			n_fill_errs++;
		end else begin
			r.status = ST_FILLED;
			r.phys   = phys_of(frame, ofs, nbits);
			if (occupancy < cap) begin
				// append into free space
				slot      = occupancy;
				occupancy = occupancy + 1;
				do_store  = 1'b1;
			end else if (cap > 0) begin
				// oldest stamp among live entries, lowest index on ties
				for (i = 1; i < cap; i++) begin
					a = (cfg_mode == MODE_FIFO) ? ins_stamp[i] : use_stamp[i];
					b = (cfg_mode == MODE_FIFO) ? ins_stamp[slot] : use_stamp[slot];
					if (a < b) slot = i;
				end
				do_store = 1'b1;
				n_evictions++;
			end
			if (do_store) begin
				tag_pid[slot]   = pid;
				tag_page[slot]  = page[PAGE_W-1:0];
				ent_frame[slot] = frame;
				ins_stamp[slot] = access_count;
				use_stamp[slot] = access_count;
				r.idx           = 4'(slot);
			end
		end
		return r;
	endfunction

	// send one request item and record its expected result on acceptance
	task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
		input logic [PID_W-1:0] pid, input logic [FRAME_W-1:0] frame, input logic ferr);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, ferr, frame, pid, addr};
		do @(posedge clk); while (!s_tready);
		tlb_expect.push_back(predict_tlb(act, addr, pid, frame, ferr));
		n_items++;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tlb_expect.size() != 0) @(posedge clk);
	endtask

	// apb write; psel stays up so writes can follow back to back
	task automatic write_reg(input reg_idx_t which, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (which)
			REG_PAGE_OFFSET: cfg_ofs_bits = value[CFG_W-1:0];
			REG_CAPACITY:    cfg_capacity = value[CFG_W-1:0];
			REG_MODE:        cfg_mode     = value[0];
			default: ;
		endcase
	endtask

	// all three registers, written only once the buffer is idle
	task automatic set_config(input logic [CFG_W-1:0] ofs, input logic [CFG_W-1:0] cap,
		input logic mode);
		wait_drained();
		write_reg(REG_PAGE_OFFSET, {27'b0, ofs});
		write_reg(REG_CAPACITY, {27'b0, cap});
		write_reg(REG_MODE, {31'b0, mode});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_settings++;
	endtask

	// reset settings: empty lookup, fill error, extremes, duplicate tags
	task automatic test_basic_lookup();
		send_item(ACT_TRANSLATE, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b1);
		send_item(ACT_FILL, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b0);
		send_item(ACT_TRANSLATE, 32'hFFFF_F000, 16'hFFFF, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'hFFFF_F5A5, 16'hFFFF, 20'h12345, 1'b0);
		send_item(ACT_TRANSLATE, 32'hFFFF_F0F0, 16'hFFFF, 20'hFFFFF, 1'b1);
		send_item(ACT_TRANSLATE, 32'hFFFF_F0F0, 16'hFFFE, 20'hFFFFF, 1'b0);
	endtask

	// offset width and capacity beyond their limits are clamped
	task automatic test_clamps();
		set_config(5'd0, 5'd31, MODE_LRU);
		send_item(ACT_TRANSLATE, 32'h0000_000F, 16'h0000, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'hABCD_E123, 16'h8001, 20'h80000, 1'b0);
		set_config(5'd31, 5'd16, MODE_LRU);
		send_item(ACT_TRANSLATE, 32'hABCD_1234, 16'h8001, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'h1234_FFFF, 16'h8001, 20'hFFFFF, 1'b0);
	endtask

	// capacity below occupancy, then fifo and lru victims
	task automatic test_eviction();
		set_config(5'd12, 5'd2, MODE_FIFO);
		send_item(ACT_TRANSLATE, 32'h0000_0ABC, 16'h0000, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'h7000_0000, 16'h0042, 20'h00777, 1'b0);
		set_config(5'd12, 5'd3, MODE_LRU);
		send_item(ACT_TRANSLATE, 32'h7000_0FFF, 16'h0042, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'h5555_5555, 16'h5555, 20'hAAAAA, 1'b0);
		send_item(ACT_TRANSLATE, 32'h5555_5000, 16'h5555, 20'h00000, 1'b0);
	endtask

	// capacity zero: lookups miss and fills store nothing
	task automatic test_disabled();
		set_config(5'd12, 5'd0, MODE_FIFO);
		send_item(ACT_TRANSLATE, 32'h5555_5000, 16'h5555, 20'h00000, 1'b0);
		send_item(ACT_FILL, 32'h8765_4321, 16'h1234, 20'h54321, 1'b0);
	endtask

	// random items mostly drawn from a small tag pool so hits and evictions are common
	task automatic run_traffic(input logic [CFG_W-1:0] ofs, input logic [CFG_W-1:0] cap,
		input logic mode, input int count, input int tx_pct, input int rx_pct);
		logic [ADDR_W-1:0] pool_addr [20];
		logic [PID_W-1:0]  pool_pid  [20];
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] addr;
		logic [PID_W-1:0]  pid;
		logic              act;
		int                k;
		set_config(ofs, cap, mode);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		mask = (32'd1 << offset_width()) - 32'd1;
		for (k = 0; k < 20; k++) begin
			pool_addr[k] = $urandom;
			pool_pid[k]  = PID_W'($urandom_range(0, 16'hFFFF));
		end
		repeat (count) begin
			k = $urandom_range(0, 19);
			if ($urandom_range(0, 99) < 85) begin
				addr = (pool_addr[k] & ~mask) | ($urandom & mask);
				pid  = pool_pid[k];
			end else begin
				addr = $urandom;
				pid  = PID_W'($urandom_range(0, 16'hFFFF));
			end
			act = ($urandom_range(0, 99) < 58) ? ACT_TRANSLATE : ACT_FILL;
			send_item(act, addr, pid, FRAME_W'($urandom_range(0, 20'hFFFFF)),
				$urandom_range(0, 9) == 0);
		end
	endtask

	// random traffic across fifo and lru, several widths and capacities
	task automatic test_random_traffic();
		run_traffic(5'd12, 5'd16, MODE_FIFO, 160, 20, 20);
		run_traffic(5'd4,  5'd16, MODE_LRU,  160, 0,  0);
		run_traffic(5'd16, 5'd4,  MODE_FIFO, 150, 30, 30);
		run_traffic(5'd31, 5'd31, MODE_LRU,  150, 10, 0);
		run_traffic(5'd0,  5'd1,  MODE_LRU,  140, 0,  30);
		run_traffic(5'd7,  5'd0,  MODE_FIFO, 80,  20, 20);
		run_traffic(5'd9,  5'd8,  MODE_LRU,  160, 30, 10);
		run_traffic(5'd5,  5'd2,  MODE_FIFO, 160, 10, 10);
		run_traffic(5'd14, 5'd12, MODE_LRU,  160, 20, 20);
	endtask

	// full rate on both sides, no idling
	task automatic test_streaming();
		run_traffic(5'd16, 5'd16, MODE_FIFO, 200, 0, 0);
	endtask

	// result check and receiver stalls
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tlb_expect.size() == 0) begin
					$error("unexpected result item: status %0d phys %h index %0d",
						m_tuser, m_tdata[31:0], m_tdata[35:32]);
					n_fails++;
				end else begin
					want = tlb_expect.pop_front();
					if (m_tuser !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
						n_fails++;
					end
					if (m_tdata[31:0] !== want.phys) begin
						$error("physical_address mismatch: expected %h, got %h",
							want.phys, m_tdata[31:0]);
						n_fails++;
					end
					if (m_tdata[35:32] !== want.idx) begin
						$error("entry_index mismatch: expected %0d, got %0d",
							want.idx, m_tdata[35:32]);
						n_fails++;
					end
				end
			end
			if (rx_hold != 0) begin
				rx_hold = rx_hold - 1;
				m_tready <= 1'b0;
			end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				rx_hold = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("tlb_fifo_lru_translation test failed");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= '0;
		m_tready     <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		cfg_ofs_bits = OFS_BITS_RST;
		cfg_capacity = CAP_RST;
		cfg_mode     = MODE_FIFO;
		occupancy    = 0;
		access_count = '0;
		n_fails      = 0;
		n_items      = 0;
		n_settings   = 1;
		n_hits       = 0;
		n_misses     = 0;
		n_evictions  = 0;
		n_fill_errs  = 0;
		tx_idle_pct  = 15;
		rx_stall_pct = 15;
		rx_hold      = 0;
		cycle_count  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_lookup();
		test_clamps();
		test_eviction();
		test_disabled();
		test_random_traffic();
		test_streaming();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d items over %0d register settings, fifo and lru", n_items,
			n_settings);
		$display("%0d hits, %0d misses, %0d evictions, %0d fill errors", n_hits, n_misses,
			n_evictions, n_fill_errs);
		if (n_fails == 0) begin
			$display("tlb_fifo_lru_translation test passed");
		end else begin
			$display("tlb_fifo_lru_translation test failed");
		end
		$finish;
	end

endmodule
